### design/ray_triangle_intersect_macros.svh
// Assertion helpers for the ray/triangle block. Clock and reset names are fixed.
`ifndef RAY_TRIANGLE_INTERSECT_MACROS_SVH
`define RAY_TRIANGLE_INTERSECT_MACROS_SVH

// same-cycle implication
`define RTI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rti: same-cycle check failed");

// next-cycle implication
`define RTI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rti: next-cycle check failed");

`endif

### design/rti_pkg.sv
`timescale 1ns / 1ps
package rti_pkg;

  localparam int CW     = 21;            // coordinate width
  localparam int FW     = 10;            // fraction bits
  localparam int DW     = CW - 1;        // distance width
  localparam int DIFW   = CW + 1;        // coordinate difference
  localparam int NW     = 2 * DIFW + 1;  // normal component
  localparam int NDW    = NW + CW;       // normal times direction
  localparam int NWW    = NW + DIFW;     // normal times (A - O)
  localparam int DENW   = NDW + 2;
  localparam int NUMW   = NWW + 2;
  localparam int REMW   = NUMW + FW;     // dividend of the divider
  localparam int QW     = DW;            // quotient bits
  localparam int CMPW   = DENW + QW;     // divider compare width
  localparam int TPW    = DW + 1 + CW;   // t times direction
  localparam int PW     = 32;            // unsaturated hit point
  localparam int VPW    = PW + 1;        // hit point minus edge start
  localparam int MW     = NW + DIFW + 1; // normal cross edge
  localparam int MLW    = 34;
  localparam int MHW    = MW - MLW;
  localparam int PPLW   = MLW + 1 + VPW;
  localparam int PPHW   = MHW + VPW;
  localparam int CTW    = MW + VPW + 1;
  localparam int TW     = CTW + 2;
  localparam int VREGW  = 3 * CW;
  localparam int IDXW   = 2;
  localparam int MATW   = 8;
  localparam int IN_TDW  = 168;
  localparam int OUT_TDW = 96;

  // register indexes
  localparam logic [IDXW-1:0] REG_VERTEX_A = 2'd0;
  localparam logic [IDXW-1:0] REG_VERTEX_B = 2'd1;
  localparam logic [IDXW-1:0] REG_VERTEX_C = 2'd2;
  localparam logic [IDXW-1:0] REG_MATERIAL = 2'd3;

  // cross product operand order
  localparam int XA [3] = '{1, 2, 0};
  localparam int XB [3] = '{2, 0, 1};

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [DW-1:0]        dist_t;
  typedef logic signed [NW-1:0] norm_t;
  typedef logic signed [MW-1:0] emat_t;

  typedef struct packed {
    logic   miss;
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t dx;
    coord_t dy;
    coord_t dz;
    dist_t  dmin;
    dist_t  dmax;
  } side_t;

endpackage

### design/rti_setup.sv
`timescale 1ns / 1ps
module rti_setup (
  input  logic                       clk_i,
  input  logic [rti_pkg::VREGW-1:0]  vert_a_i,
  input  logic [rti_pkg::VREGW-1:0]  vert_b_i,
  input  logic [rti_pkg::VREGW-1:0]  vert_c_i,
  output rti_pkg::coord_t            vtx_o  [3][3],
  output rti_pkg::norm_t             norm_o [3],
  output rti_pkg::emat_t             emat_o [3][3]
);

  localparam int CW   = rti_pkg::CW;
  localparam int DIFW = rti_pkg::DIFW;
  localparam int NW   = rti_pkg::NW;
  localparam int MW   = rti_pkg::MW;
  localparam int P1W  = 2 * DIFW;
  localparam int P2W  = NW + DIFW;

  logic signed [DIFW-1:0] ab [3];
  logic signed [DIFW-1:0] ac [3];
  logic signed [DIFW-1:0] edg [3][3];
  logic signed [P1W-1:0]  np_q [3][2];
  rti_pkg::norm_t         norm_q [3];
  logic signed [P2W-1:0]  mp_q [3][3][2];
  rti_pkg::emat_t         emat_q [3][3];

  for (genvar k = 0; k < 3; k++) begin : g_unpack
    assign vtx_o[0][k] = vert_a_i[k*CW +: CW];
    assign vtx_o[1][k] = vert_b_i[k*CW +: CW];
    assign vtx_o[2][k] = vert_c_i[k*CW +: CW];
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = DIFW'(vtx_o[0][k]) - DIFW'(vtx_o[1][k]);
      ac[k] = DIFW'(vtx_o[0][k]) - DIFW'(vtx_o[2][k]);
      edg[0][k] = DIFW'(vtx_o[1][k]) - DIFW'(vtx_o[0][k]);
      edg[1][k] = DIFW'(vtx_o[2][k]) - DIFW'(vtx_o[1][k]);
      edg[2][k] = DIFW'(vtx_o[0][k]) - DIFW'(vtx_o[2][k]);
    end
  end

  // plane normal (A-B) x (A-C), then normal x edge for each edge
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      np_q[k][0] <= P1W'(ab[rti_pkg::XA[k]]) * P1W'(ac[rti_pkg::XB[k]]);
      np_q[k][1] <= P1W'(ab[rti_pkg::XB[k]]) * P1W'(ac[rti_pkg::XA[k]]);
      norm_q[k]  <= NW'(np_q[k][0]) - NW'(np_q[k][1]);
    end
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        mp_q[e][k][0] <= P2W'(norm_q[rti_pkg::XA[k]]) * P2W'(edg[e][rti_pkg::XB[k]]);
        mp_q[e][k][1] <= P2W'(norm_q[rti_pkg::XB[k]]) * P2W'(edg[e][rti_pkg::XA[k]]);
        emat_q[e][k]  <= MW'(mp_q[e][k][0]) - MW'(mp_q[e][k][1]);
      end
    end
  end

  assign norm_o = norm_q;
  assign emat_o = emat_q;

endmodule

### design/rti_div.sv
`timescale 1ns / 1ps
module rti_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rti_pkg::REMW-1:0]    rem_i,
  input  logic [rti_pkg::DENW-1:0]    den_i,
  input  rti_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [rti_pkg::QW-1:0]      quot_o,
  output rti_pkg::side_t              side_o
);

  localparam int QW   = rti_pkg::QW;
  localparam int REMW = rti_pkg::REMW;
  localparam int DENW = rti_pkg::DENW;
  localparam int CMPW = rti_pkg::CMPW;

  logic                valid_q [QW];
  logic [REMW-1:0]     rem_q   [QW];
  logic [DENW-1:0]     den_q   [QW];
  logic [QW-1:0]       quot_q  [QW];
  rti_pkg::side_t      side_q  [QW];

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int Sh = QW - 1 - s;
    logic            v_in;
    logic [REMW-1:0] r_in;
    logic [DENW-1:0] d_in;
    logic [QW-1:0]   q_in;
    rti_pkg::side_t  sd_in;
    logic [CMPW-1:0] r_ext;
    logic [CMPW-1:0] d_sh;
    logic            take;

    if (s == 0) begin : g_first
      assign v_in  = valid_i;
      assign r_in  = rem_i;
      assign d_in  = den_i;
      assign q_in  = '0;
      assign sd_in = side_i;
    end else begin : g_next
      assign v_in  = valid_q[s-1];
      assign r_in  = rem_q[s-1];
      assign d_in  = den_q[s-1];
      assign q_in  = quot_q[s-1];
      assign sd_in = side_q[s-1];
    end

    assign r_ext = CMPW'(r_in);
    assign d_sh  = CMPW'(d_in) << Sh;
    assign take  = r_ext >= d_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= take ? REMW'(r_ext - d_sh) : r_in;
        den_q[s]  <= d_in;
        quot_q[s] <= q_in | (QW'(take) << Sh);
        side_q[s] <= sd_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### design/ray_triangle_intersect.sv
`timescale 1ns / 1ps
// Channel   | Signals                          | Contents
// ----------+----------------------------------+----------------------------------------
// ray in    | s_axis_tvalid/tready/tdata[167:0]| origin, direction, distance window
// result    | m_axis_tvalid/tready/tdata[95:0] | distance, hit point, material; tuser=hit
// config    | cfg_we_i, cfg_idx_i, cfg_data_i  | vertices A, B, C and material tag
//
// One ray per cycle while the result is not stalled; the quotient pipeline
// (one quotient bit per stage) turns the two plane dot products into t.
// Reset clears the triangle registers and all stage valid bits.
// All stages move together; a stalled result freezes the whole pipeline.
// After a vertex write, norm_q settles via np_q and the edge terms via mp_q and emat_q.
`include "ray_triangle_intersect_macros.svh"
module ray_triangle_intersect (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, dist_min, dist_max
  input  logic [rti_pkg::IN_TDW-1:0]    s_axis_tdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // hit_dist, point_x, point_y, point_z, hit_material
  output logic [rti_pkg::OUT_TDW-1:0]   m_axis_tdata,
  // is_hit
  output logic [0:0]                    m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_we_i,
  input  logic [rti_pkg::IDXW-1:0]      cfg_idx_i,
  input  logic [rti_pkg::VREGW-1:0]     cfg_data_i
);

  localparam int CW   = rti_pkg::CW;
  localparam int DW   = rti_pkg::DW;
  localparam int FW   = rti_pkg::FW;
  localparam int DIFW = rti_pkg::DIFW;
  localparam int NDW  = rti_pkg::NDW;
  localparam int NWW  = rti_pkg::NWW;
  localparam int DENW = rti_pkg::DENW;
  localparam int NUMW = rti_pkg::NUMW;
  localparam int REMW = rti_pkg::REMW;
  localparam int TPW  = rti_pkg::TPW;
  localparam int PW   = rti_pkg::PW;
  localparam int VPW  = rti_pkg::VPW;
  localparam int MLW  = rti_pkg::MLW;
  localparam int MW   = rti_pkg::MW;
  localparam int PPLW = rti_pkg::PPLW;
  localparam int PPHW = rti_pkg::PPHW;
  localparam int CTW  = rti_pkg::CTW;
  localparam int TW   = rti_pkg::TW;
  localparam int MATW = rti_pkg::MATW;
  localparam int PADW = rti_pkg::OUT_TDW - DW - 3 * CW - MATW;

  // configuration registers
  logic [rti_pkg::VREGW-1:0] vert_q [3];
  logic [MATW-1:0]           mat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q[0] <= '0;
      vert_q[1] <= '0;
      vert_q[2] <= '0;
      mat_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rti_pkg::REG_VERTEX_A: vert_q[0] <= cfg_data_i;
        rti_pkg::REG_VERTEX_B: vert_q[1] <= cfg_data_i;
        rti_pkg::REG_VERTEX_C: vert_q[2] <= cfg_data_i;
        rti_pkg::REG_MATERIAL: mat_q     <= cfg_data_i[MATW-1:0];
        default: ;
      endcase
    end
  end

  rti_pkg::coord_t vtx   [3][3];
  rti_pkg::norm_t  norm  [3];
  rti_pkg::emat_t  emat  [3][3];

  rti_setup u_setup (
    .clk_i    (clk_i),
    .vert_a_i (vert_q[0]),
    .vert_b_i (vert_q[1]),
    .vert_c_i (vert_q[2]),
    .vtx_o    (vtx),
    .norm_o   (norm),
    .emat_o   (emat)
  );

  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: capture ray, form A - O
  logic                   v1_q;
  rti_pkg::coord_t        o1_q [3];
  rti_pkg::coord_t        d1_q [3];
  logic signed [DIFW-1:0] w1_q [3];
  rti_pkg::dist_t         dmin1_q, dmax1_q;

  // stage 2: wait for the plane normal
  logic                   v2_q;
  rti_pkg::coord_t        o2_q [3];
  rti_pkg::coord_t        d2_q [3];
  logic signed [DIFW-1:0] w2_q [3];
  rti_pkg::dist_t         dmin2_q, dmax2_q;

  // stage 3: dot product terms
  logic                   v3_q;
  rti_pkg::coord_t        o3_q [3];
  rti_pkg::coord_t        d3_q [3];
  logic signed [NDW-1:0]  nd3_q [3];
  logic signed [NWW-1:0]  nw3_q [3];
  rti_pkg::dist_t         dmin3_q, dmax3_q;

  // stage 4: dot product sums
  logic                   v4_q;
  rti_pkg::coord_t        o4_q [3];
  rti_pkg::coord_t        d4_q [3];
  logic signed [DENW-1:0] den4_q;
  logic signed [NUMW-1:0] num4_q;
  rti_pkg::dist_t         dmin4_q, dmax4_q;

  // stage 5: parallel and sign tests, magnitudes
  logic                   v5_q;
  logic                   miss5_q;
  rti_pkg::coord_t        o5_q [3];
  rti_pkg::coord_t        d5_q [3];
  logic [DENW-1:0]        dmag5_q;
  logic [NUMW-1:0]        nmag5_q;
  rti_pkg::dist_t         dmin5_q, dmax5_q;

  // stage 6: quotient range test
  logic                   v6_q;
  logic [REMW-1:0]        rem6_q;
  logic [DENW-1:0]        den6_q;
  rti_pkg::side_t         side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o1_q[k] <= s_axis_tdata[k*CW +: CW];
        d1_q[k] <= s_axis_tdata[(3+k)*CW +: CW];
        w1_q[k] <= DIFW'(vtx[0][k]) - DIFW'($signed(s_axis_tdata[k*CW +: CW]));
        o2_q[k] <= o1_q[k];
        d2_q[k] <= d1_q[k];
        w2_q[k] <= w1_q[k];
        o3_q[k] <= o2_q[k];
        d3_q[k] <= d2_q[k];
        nd3_q[k] <= NDW'(norm[k]) * NDW'(d2_q[k]);
        nw3_q[k] <= NWW'(norm[k]) * NWW'(w2_q[k]);
        o4_q[k] <= o3_q[k];
        d4_q[k] <= d3_q[k];
        o5_q[k] <= o4_q[k];
        d5_q[k] <= d4_q[k];
      end
      dmin1_q <= s_axis_tdata[6*CW +: DW];
      dmax1_q <= s_axis_tdata[6*CW+DW +: DW];
      dmin2_q <= dmin1_q;
      dmax2_q <= dmax1_q;
      dmin3_q <= dmin2_q;
      dmax3_q <= dmax2_q;

      den4_q  <= DENW'(nd3_q[0]) + DENW'(nd3_q[1]) + DENW'(nd3_q[2]);
      num4_q  <= NUMW'(nw3_q[0]) + NUMW'(nw3_q[1]) + NUMW'(nw3_q[2]);
      dmin4_q <= dmin3_q;
      dmax4_q <= dmax3_q;

      // miss when the ray runs parallel or the hit lies behind the origin
      miss5_q <= (den4_q == '0) ||
                 ((num4_q != '0) && (num4_q[NUMW-1] != den4_q[DENW-1]));
      dmag5_q <= den4_q[DENW-1] ? DENW'(-den4_q) : DENW'(den4_q);
      nmag5_q <= num4_q[NUMW-1] ? NUMW'(-num4_q) : NUMW'(num4_q);
      dmin5_q <= dmin4_q;
      dmax5_q <= dmax4_q;

      // a quotient that would not fit the distance field is a miss
      rem6_q  <= {nmag5_q, {FW{1'b0}}};
      den6_q  <= dmag5_q;
      side6_q <= '{miss: miss5_q || (REMW'(nmag5_q) >= (REMW'(dmag5_q) << (DW - FW))),
                   ox: o5_q[0], oy: o5_q[1], oz: o5_q[2],
                   dx: d5_q[0], dy: d5_q[1], dz: d5_q[2],
                   dmin: dmin5_q, dmax: dmax5_q};
    end
  end

  logic           dv_vld;
  logic [DW-1:0]  dv_quot;
  rti_pkg::side_t dv_side;

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .rem_i   (rem6_q),
    .den_i   (den6_q),
    .side_i  (side6_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  rti_pkg::coord_t dvo [3];
  rti_pkg::coord_t dvd [3];

  assign dvo[0] = dv_side.ox;
  assign dvo[1] = dv_side.oy;
  assign dvo[2] = dv_side.oz;
  assign dvd[0] = dv_side.dx;
  assign dvd[1] = dv_side.dy;
  assign dvd[2] = dv_side.dz;

  // stage 7: window test, t * D
  logic                   v7_q, miss7_q;
  rti_pkg::dist_t         t7_q;
  rti_pkg::coord_t        o7_q [3];
  logic signed [TPW-1:0]  tp7_q [3];
  // stage 8: hit point
  logic                   v8_q, miss8_q;
  rti_pkg::dist_t         t8_q;
  logic signed [PW-1:0]   p8_q [3];
  // stage 9: point relative to each edge start
  logic                   v9_q, miss9_q;
  rti_pkg::dist_t         t9_q;
  logic signed [PW-1:0]   p9_q [3];
  logic signed [VPW-1:0]  vp9_q [3][3];
  // stage 10: split edge products
  logic                   v10_q, miss10_q;
  rti_pkg::dist_t         t10_q;
  logic signed [PW-1:0]   p10_q [3];
  logic signed [PPLW-1:0] pl10_q [3][3];
  logic signed [PPHW-1:0] ph10_q [3][3];
  // stage 11: joined edge products
  logic                   v11_q, miss11_q;
  rti_pkg::dist_t         t11_q;
  logic signed [PW-1:0]   p11_q [3];
  logic signed [CTW-1:0]  ct11_q [3][3];
  // stage 12: edge sums
  logic                   v12_q, miss12_q;
  rti_pkg::dist_t         t12_q;
  logic signed [PW-1:0]   p12_q [3];

  logic signed [TW-1:0]   tot [3];
  logic [2:0]             eneg;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      tot[e]  = TW'(ct11_q[e][0]) + TW'(ct11_q[e][1]) + TW'(ct11_q[e][2]);
      eneg[e] = tot[e][TW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
    end else if (en) begin
      v7_q  <= dv_vld;
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      miss7_q <= dv_side.miss || (dv_quot < dv_side.dmin) || (dv_quot > dv_side.dmax);
      t7_q    <= dv_quot;
      for (int k = 0; k < 3; k++) begin
        o7_q[k]  <= dvo[k];
        tp7_q[k] <= TPW'($signed({1'b0, dv_quot})) * TPW'(dvd[k]);
      end

      miss8_q <= miss7_q;
      t8_q    <= t7_q;
      for (int k = 0; k < 3; k++) begin
        p8_q[k] <= PW'(o7_q[k]) + PW'(tp7_q[k] >>> FW);
      end

      miss9_q <= miss8_q;
      t9_q    <= t8_q;
      p9_q    <= p8_q;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          vp9_q[e][k] <= VPW'(p8_q[k]) - VPW'(vtx[e][k]);
        end
      end

      miss10_q <= miss9_q;
      t10_q    <= t9_q;
      p10_q    <= p9_q;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          pl10_q[e][k] <= PPLW'($signed({1'b0, emat[e][k][MLW-1:0]})) *
                          PPLW'(vp9_q[e][k]);
          ph10_q[e][k] <= PPHW'($signed(emat[e][k][MW-1:MLW])) * PPHW'(vp9_q[e][k]);
        end
      end

      miss11_q <= miss10_q;
      t11_q    <= t10_q;
      p11_q    <= p10_q;
      for (int e = 0; e < 3; e++) begin
        for (int k = 0; k < 3; k++) begin
          ct11_q[e][k] <= (CTW'(ph10_q[e][k]) <<< MLW) + CTW'(pl10_q[e][k]);
        end
      end

      // drop the hit if the point lies outside any edge
      miss12_q <= miss11_q || (eneg != '0);
      t12_q    <= t11_q;
      p12_q    <= p11_q;
    end
  end

  // output register
  logic [CW-1:0]           pt_sat [3];
  logic [rti_pkg::OUT_TDW-1:0] out_data_q;
  logic                    out_hit_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if ((p12_q[k][PW-1:CW-1] == '0) || (p12_q[k][PW-1:CW-1] == '1)) begin
        pt_sat[k] = p12_q[k][CW-1:0];
      end else if (p12_q[k][PW-1]) begin
        pt_sat[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt_sat[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= !miss12_q;
      if (miss12_q) begin
        out_data_q <= '0;
      end else begin
        out_data_q <= {{PADW{1'b0}}, mat_q, pt_sat[2], pt_sat[1], pt_sat[0], t12_q};
      end
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_hit_q;

  `RTI_ASSERT_IMP(a_miss_clears, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
  `RTI_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `RTI_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v1_q)

endmodule
